// File: rtl/color_matrix_clamp_core_defines.svh
// Assertion macros shared by the color matrix checker.
`ifndef COLOR_MATRIX_CLAMP_CORE_DEFINES_SVH
`define COLOR_MATRIX_CLAMP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CMC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Delayed implication, disabled while reset is asserted.
`define CMC_ASSERT_LAT2(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// File: rtl/cmc_pkg.sv
// Types, constants and helper functions of the color matrix clamp block.
package cmc_pkg;

    // Channel and coefficient geometry.
    localparam int NUM_CH        = 4;
    localparam int CH_W          = 8;
    localparam int COEF_W        = 16;
    localparam int FRACTION_BITS = 12;
    localparam int ROW_W         = NUM_CH * COEF_W;
    localparam int THRESH_W      = NUM_CH * CH_W;
    localparam int CFG_DATA_W    = ROW_W;
    localparam int CFG_INDEX_W   = 3;

    // Arithmetic widths: signed coefficient times zero-extended channel, then a sum of four.
    localparam int PROD_W  = COEF_W + CH_W + 1;
    localparam int SUM_W   = PROD_W + 2;
    localparam int FLOOR_W = SUM_W - FRACTION_BITS;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COEF_RED   = 3'd0,
        REG_COEF_GREEN = 3'd1,
        REG_COEF_BLUE  = 3'd2,
        REG_COEF_ALPHA = 3'd3,
        REG_MIN_THRESH = 3'd4,
        REG_MAX_THRESH = 3'd5
    } cfg_index_t;

    // Input pixel transaction.
    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
        logic [CH_W-1:0] in_alpha;
    } pixel_t;

    // Result pixel transaction.
    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } result_t;

    // Row of the identity matrix: unity at column k, zero elsewhere.
    function automatic logic [ROW_W-1:0] identity_row(input int k);
        logic [ROW_W-1:0] row;
        row = '0;
        row[k*COEF_W +: COEF_W] = COEF_W'(1 << FRACTION_BITS);
        return row;
    endfunction

    // Signed coefficient of a row that weights input channel k.
    function automatic logic signed [COEF_W-1:0] coef_at(input logic [ROW_W-1:0] row,
                                                         input int k);
        return $signed(row[k*COEF_W +: COEF_W]);
    endfunction

endpackage

// File: rtl/color_matrix_clamp_core.sv
// Top level of the RGBA 4x4 color matrix transform with per-channel clamping.
// A pixel is accepted on every clock edge where start is high; busy is always low, so the
// core takes one pixel per clock with no gaps. Each result appears on result for exactly one
// cycle, marked by done. An accepted pixel is held in the input register and its result in the
// result register, which is loaded from the sixteen 16x9 products, their row sums, the floor
// and the clamps. The receiver cannot stall the core and must take each result in the cycle
// done is high. Coefficients are signed Q4.12; the sum is floored, raised to the channel
// minimum, then lowered to the channel maximum, so the maximum wins when the minimum is above
// it. Configuration must be written through wr_en, wr_index and wr_data while no pixel is in
// flight; the core itself does not enforce this. Writes to unknown indexes are ignored.
module color_matrix_clamp_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  cmc_pkg::pixel_t                     pixel,
    output logic                                done,
    output cmc_pkg::result_t                    result,
    input  logic                                wr_en,
    input  logic [cmc_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [cmc_pkg::CFG_DATA_W-1:0]      wr_data
);

    // Configuration registers.
    logic [cmc_pkg::ROW_W-1:0]    coef_reg [cmc_pkg::NUM_CH];
    logic [cmc_pkg::THRESH_W-1:0] min_reg;
    logic [cmc_pkg::THRESH_W-1:0] max_reg;

    // Pipeline registers.
    logic                                     in_valid_reg;
    cmc_pkg::pixel_t                          pixel_reg;
    logic                                     done_reg;
    cmc_pkg::result_t                         result_reg;
    cmc_pkg::result_t                         result_next;

    // Per-channel intermediate values between the two registers.
    logic [cmc_pkg::CH_W-1:0]                 px       [cmc_pkg::NUM_CH];
    logic signed [cmc_pkg::PROD_W-1:0]        prod     [cmc_pkg::NUM_CH][cmc_pkg::NUM_CH];
    logic signed [cmc_pkg::SUM_W-1:0]         sum      [cmc_pkg::NUM_CH];
    logic signed [cmc_pkg::FLOOR_W-1:0]       floored  [cmc_pkg::NUM_CH];
    logic signed [cmc_pkg::FLOOR_W-1:0]       lo_s     [cmc_pkg::NUM_CH];
    logic signed [cmc_pkg::FLOOR_W-1:0]       hi_s     [cmc_pkg::NUM_CH];
    logic signed [cmc_pkg::FLOOR_W-1:0]       lifted   [cmc_pkg::NUM_CH];
    logic signed [cmc_pkg::FLOOR_W-1:0]       clamped  [cmc_pkg::NUM_CH];

    // The pipeline never stalls, so the core is always ready.
    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // Configuration writes; unknown indexes leave every register unchanged.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cmc_pkg::NUM_CH; i++)
            begin
                coef_reg[i] <= cmc_pkg::identity_row(i);
            end
            min_reg <= '0;
            max_reg <= '1;
        end
        else if (wr_en)
        begin
            unique case (cmc_pkg::cfg_index_t'(wr_index))
                cmc_pkg::REG_COEF_RED:   coef_reg[0] <= wr_data;
                cmc_pkg::REG_COEF_GREEN: coef_reg[1] <= wr_data;
                cmc_pkg::REG_COEF_BLUE:  coef_reg[2] <= wr_data;
                cmc_pkg::REG_COEF_ALPHA: coef_reg[3] <= wr_data;
                cmc_pkg::REG_MIN_THRESH: min_reg <= wr_data[cmc_pkg::THRESH_W-1:0];
                cmc_pkg::REG_MAX_THRESH: max_reg <= wr_data[cmc_pkg::THRESH_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Valid bits of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
            done_reg     <= in_valid_reg;
        end
    end

    // Payload registers; they load every cycle and carry no reset.
    always_ff @(posedge clk)
    begin
        pixel_reg  <= pixel;
        result_reg <= result_next;
    end

    // Sixteen coefficient by channel products; channels are zero-extended to stay positive.
    always_comb
    begin
        px[0] = pixel_reg.in_red;
        px[1] = pixel_reg.in_green;
        px[2] = pixel_reg.in_blue;
        px[3] = pixel_reg.in_alpha;
        for (int r = 0; r < cmc_pkg::NUM_CH; r++)
        begin
            for (int c = 0; c < cmc_pkg::NUM_CH; c++)
            begin
                prod[r][c] = cmc_pkg::coef_at(coef_reg[r], c) * $signed({1'b0, px[c]});
            end
        end
    end

    // Sum each row, floor by dropping the fraction bits, then apply min and max clamps.
    // Both thresholds lie in 0..255, so the clamped value already fits one byte.
    always_comb
    begin
        for (int r = 0; r < cmc_pkg::NUM_CH; r++)
        begin
            sum[r] = cmc_pkg::SUM_W'(prod[r][0]) + cmc_pkg::SUM_W'(prod[r][1])
                   + cmc_pkg::SUM_W'(prod[r][2]) + cmc_pkg::SUM_W'(prod[r][3]);
            floored[r] = $signed(sum[r][cmc_pkg::SUM_W-1:cmc_pkg::FRACTION_BITS]);
            lo_s[r] = $signed({{(cmc_pkg::FLOOR_W-cmc_pkg::CH_W){1'b0}},
                               min_reg[r*cmc_pkg::CH_W +: cmc_pkg::CH_W]});
            hi_s[r] = $signed({{(cmc_pkg::FLOOR_W-cmc_pkg::CH_W){1'b0}},
                               max_reg[r*cmc_pkg::CH_W +: cmc_pkg::CH_W]});
            lifted[r]  = (floored[r] < lo_s[r]) ? lo_s[r] : floored[r];
            clamped[r] = (lifted[r] > hi_s[r]) ? hi_s[r] : lifted[r];
        end
        result_next.out_red   = clamped[0][cmc_pkg::CH_W-1:0];
        result_next.out_green = clamped[1][cmc_pkg::CH_W-1:0];
        result_next.out_blue  = clamped[2][cmc_pkg::CH_W-1:0];
        result_next.out_alpha = clamped[3][cmc_pkg::CH_W-1:0];
    end

endmodule

// File: rtl/cmc_checker.sv
// Port-level checker of the color matrix clamp core and its bind statement.
`include "color_matrix_clamp_core_defines.svh"

module cmc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // The core never refuses a pixel.
    `CMC_ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy, "core reported busy")

    // Every accepted transaction produces a result, through the input valid and done registers.
    `CMC_ASSERT_LAT2(a_accept_gives_done, clk, rst_n, start && !busy, done, "result missing")

    // No result appears without an earlier accepted transaction.
    `CMC_ASSERT_IMPL(a_done_has_accept, clk, rst_n, done, $past(start && !busy, 2), "stray result")

endmodule

bind color_matrix_clamp_core cmc_checker u_cmc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
